### sv/gdad_pkg.sv
// Package for the Gregorian date add-days unit.
// Holds the request/result payload types, controller state and command types,
// and the calendar tables. No dependencies.
package gdad_pkg;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
		logic [14:0] offset_days;
	} gdad_in_t;

	typedef struct packed {
		logic [4:0]  result_day;
		logic [3:0]  result_month;
		logic [13:0] result_year;
	} gdad_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_RMD,
		ST_DOY,
		ST_WALK
	} gdad_state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic rmd;
		logic doy;
		logic step;
		logic capture;
	} gdad_cmd_t;

	typedef struct packed {
		logic walk_done;
	} gdad_status_t;

	// year / 100 as (year * DIV100_MUL) >> DIV100_SHIFT, exact for year < 32768
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic [6:0]  CENTURY      = 7'd100;
	localparam logic [6:0]  CENTURY_LAST = 7'd99;
	localparam logic [8:0]  YEAR_LEN     = 9'd365;
	localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
	localparam logic [3:0]  JANUARY      = 4'd1;
	localparam logic [3:0]  FEBRUARY     = 4'd2;
	localparam logic [3:0]  MARCH        = 4'd3;

	// Days in the months before month m of a common year; months past 12 count the whole year.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			default:    d = 9'd365;
		endcase
		return d;
	endfunction

	// Length of month m; months outside 1..12 are empty.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] l;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
			4'd2:                                       l = leap ? 5'd29 : 5'd28;
			default:                                    l = 5'd0;
		endcase
		return l;
	endfunction

endpackage

### sv/gdad_ctrl.sv
// Controller for the date add-days unit: sequences load, year split,
// day-of-year, walk and result capture. Depends on gdad_pkg.
module gdad_ctrl
	import gdad_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  gdad_status_t status,
	output gdad_cmd_t    cmd
);

	gdad_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_RMD;
			end
			ST_RMD: begin
				cmd.rmd = 1'b1;
				state_d = ST_DOY;
			end
			ST_DOY: begin
				cmd.doy = 1'b1;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!status.walk_done) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					// hold the finished date until the result register frees up
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/gdad_dpath.sv
// Datapath for the date add-days unit: operand registers, century split of
// the year, remainder walk and result register. Depends on gdad_pkg.
module gdad_dpath
	import gdad_pkg::*;
(
	input  logic         clk,
	input  gdad_in_t     in_data,
	input  gdad_cmd_t    cmd,
	output gdad_status_t status,
	output gdad_out_t    out_data
);

	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [14:0] year_q;
	logic [14:0] ofs_q;
	logic [7:0]  cent_q;
	logic [6:0]  r100_q;
	logic [15:0] rem_q;
	logic [3:0]  m_q;
	gdad_out_t   out_q;

	logic [27:0] prod;
	logic [14:0] cent_x100;
	logic        leap;
	logic [8:0]  yl;
	logic [4:0]  ml;
	logic        year_adv;
	logic        month_adv;
	logic [15:0] doy;

	assign prod      = 28'(year_q[13:0] * DIV100_MUL);
	assign cent_x100 = 15'(cent_q * CENTURY);

	assign leap = (year_q[1:0] == 2'b00 && r100_q != 7'd0) ||
	              (r100_q == 7'd0 && cent_q[1:0] == 2'b00);

	assign yl        = leap ? LEAP_YEAR_LEN : YEAR_LEN;
	assign ml        = month_len(m_q, leap);
	assign year_adv  = {7'd0, yl} < rem_q;
	assign month_adv = !year_adv && ({11'd0, ml} < rem_q);

	assign status.walk_done = !year_adv && !month_adv;

	assign doy = 16'(days_before(month_q)) + 16'(leap && month_q >= MARCH) +
	             16'(day_q) + 16'(ofs_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= in_data.start_day;
			month_q <= in_data.start_month;
			year_q  <= {1'b0, in_data.start_year};
			ofs_q   <= in_data.offset_days;
		end
		if (cmd.div) begin
			cent_q <= prod[DIV100_SHIFT +: 8];
		end
		if (cmd.rmd) begin
			r100_q <= 7'(year_q - cent_x100);
		end
		if (cmd.doy) begin
			rem_q <= doy;
			m_q   <= JANUARY;
		end
		if (cmd.step) begin
			if (year_adv) begin
				year_q <= year_q + 15'd1;
				rem_q  <= rem_q - 16'(yl);
				// keep the century split in step with the year
				if (r100_q == CENTURY_LAST) begin
					r100_q <= 7'd0;
					cent_q <= cent_q + 8'd1;
				end else begin
					r100_q <= r100_q + 7'd1;
				end
			end else if (month_adv) begin
				m_q   <= m_q + 4'd1;
				rem_q <= rem_q - 16'(ml);
			end
		end
		if (cmd.capture) begin
			out_q.result_day   <= rem_q[4:0];
			out_q.result_month <= m_q;
			out_q.result_year  <= year_q[13:0];
		end
	end

	assign out_data = out_q;

endmodule

### sv/gregorian_date_add_days_unit.sv
// Gregorian date add-days unit, top level.
// Instantiates gdad_ctrl and gdad_dpath; depends on gdad_pkg.
//
// Usage:
//   Request channel: in_valid / in_stall / in_data (start date and day offset).
//   Result channel: out_valid / out_stall / out_data (resulting date).
//   One request is worked at a time; in_stall stays high from acceptance
//   until the result is written into the output register.
// Sequence: load, divide year by 100, remainder, day of year, then one
//   walk step per whole year and per month walked off, then capture; the
//   number of walk steps follows the start date and the offset.
// Overlap: a new request is taken only once the previous one is captured,
//   and can be taken while the previous result still waits in the output register.
// Stall: a stalled result stays in the output register; a finished walk
//   holds until that register frees up.
// Reset: clears the controller to idle and drops out_valid.
module gregorian_date_add_days_unit
	import gdad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  gdad_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output gdad_out_t out_data
);

	gdad_cmd_t    cmd;
	gdad_status_t status;

	gdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	gdad_dpath u_dpath (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while a request is still in work");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.result_month >= JANUARY && out_data.result_month <= 4'd12))
		else $error("result month out of range");

	a_new_result_needs_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid) && $past(out_stall) |-> out_valid && $stable(out_data))
		else $error("stalled result overwritten");

endmodule

### tb/gregorian_date_add_days_unit_test.sv
// Testbench for gregorian_date_add_days_unit: drives start dates with day offsets and
// checks every resulting date against a calendar walk computed here.
// Depends on gdad_pkg and the gregorian_date_add_days_unit RTL.
module gregorian_date_add_days_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gdad_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT  = 800000;

	typedef enum {
		TRAFFIC_STEADY,
		TRAFFIC_SEND_IDLE,
		TRAFFIC_RECV_STALL,
		TRAFFIC_BOTH,
		TRAFFIC_HOLD
	} traffic_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	gdad_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	gdad_out_t out_data;

	gdad_in_t  pending_requests[$];
	gdad_out_t expected_dates[$];
	gdad_out_t expected_date;
	traffic_t  traffic        = TRAFFIC_STEADY;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        hold_cnt       = 0;
	int        cycle_cnt      = 0;
	int        mismatch_cnt   = 0;
	logic      req_taken      = 1'b0;

	gregorian_date_add_days_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			FEBRUARY:              return is_leap(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic int unsigned days_in_year(input int unsigned y);
		return is_leap(y) ? 366 : 365;
	endfunction

	// Day of year plus offset, then peel off whole years and months from January.
	// The year count runs wider than the field so leap tests past 16383 stay right.
	function automatic gdad_out_t date_after(input gdad_in_t req);
		int unsigned yr;
		int unsigned rem;
		int unsigned mon;
		bit          done;
		gdad_out_t   res;
		yr   = req.start_year;
		rem  = 0;
		done = 1'b0;
		for (mon = JANUARY; mon < req.start_month; mon++)
			rem += days_in_month(mon, yr);
		rem += req.start_day + req.offset_days;
		mon = JANUARY;
		while (!done) begin
			if (days_in_year(yr) < rem) begin
				rem -= days_in_year(yr);
				yr++;
			end else if (days_in_month(mon, yr) < rem) begin
				rem -= days_in_month(mon, yr);
				mon++;
			end else begin
				done = 1'b1;
			end
		end
		res.result_day   = rem[4:0];
		res.result_month = mon[3:0];
		res.result_year  = yr[13:0];
		return res;
	endfunction

	task automatic queue_date(input int d, input int m, input int y, input int ofs);
		gdad_in_t req;
		req.start_day   = d[4:0];
		req.start_month = m[3:0];
		req.start_year  = y[13:0];
		req.offset_days = ofs[14:0];
		pending_requests.push_back(req);
	endtask

	// Mostly real dates with random offsets; the rest is raw field noise.
	task automatic queue_random_dates(input int n);
		int m;
		int y;
		int ofs;
		int pick;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 75) begin
				m = $urandom_range(12, 1);
				y = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999);
				pick = $urandom_range(99);
				if (pick < 50)
					ofs = $urandom_range(32767);
				else if (pick < 80)
					ofs = $urandom_range(400);
				else
					ofs = $urandom_range(40);
				queue_date($urandom_range(days_in_month(m, y), 1), m, y, ofs);
			end else begin
				queue_date($urandom_range(31), $urandom_range(15), $urandom_range(16383),
					$urandom_range(32767));
			end
		end
	endtask

	// Set the traffic shape, queue n dates, then wait until all are sent and all results are back.
	task automatic run_phase(input traffic_t mode, input int n);
		traffic = mode;
		case (mode)
			TRAFFIC_STEADY:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			TRAFFIC_SEND_IDLE:  begin send_idle_pct = 51; recv_stall_pct = 0;  end
			TRAFFIC_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			TRAFFIC_BOTH:       begin send_idle_pct = 19; recv_stall_pct = 19; end
			TRAFFIC_HOLD:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			default:            begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		endcase
		queue_random_dates(n);
		while (pending_requests.size() != 0 || in_valid || expected_dates.size() != 0)
			@(posedge clk);
	endtask

	// Request driver: advance only once the current request has been taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= pending_requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result stall: one long hold-off in the hold phase, random stalls otherwise.
	always @(negedge clk) begin
		if (traffic == TRAFFIC_HOLD && hold_cnt < HOLD_CYCLES) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result with no request pending: day %0d month %0d year %0d",
						out_data.result_day, out_data.result_month, out_data.result_year);
					mismatch_cnt++;
				end else begin
					expected_date = expected_dates.pop_front();
					if (out_data.result_day !== expected_date.result_day) begin
						$error("result_day: expected %0d, got %0d",
							expected_date.result_day, out_data.result_day);
						mismatch_cnt++;
					end
					if (out_data.result_month !== expected_date.result_month) begin
						$error("result_month: expected %0d, got %0d",
							expected_date.result_month, out_data.result_month);
						mismatch_cnt++;
					end
					if (out_data.result_year !== expected_date.result_year) begin
						$error("result_year: expected %0d, got %0d",
							expected_date.result_year, out_data.result_year);
						mismatch_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_dates.push_back(date_after(in_data));
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		queue_date(1, 1, 0, 0);
		queue_date(31, 12, 9999, 32767);
		queue_date(0, 1, 2024, 0);         // day zero, no offset
		queue_date(0, 0, 2023, 0);
		queue_date(15, 0, 2023, 100);      // month zero
		queue_date(10, 13, 2023, 5);       // month past December
		queue_date(31, 15, 16383, 32767);  // year wraps
		queue_date(29, 2, 2000, 1);
		queue_date(28, 2, 1900, 1);        // century, not leap
		queue_date(28, 2, 2100, 366);
		queue_date(29, 2, 2024, 365);
		queue_date(31, 2, 2023, 0);        // day past month end
		queue_date(31, 4, 2023, 0);
		queue_date(31, 12, 1999, 1);
		queue_date(1, 3, 2000, 0);
		queue_date(30, 12, 2000, 1);
		queue_date(31, 12, 2000, 1);
		queue_date(1, 1, 0, 32767);
		queue_date(31, 1, 0, 59);
		queue_date(0, 5, 1600, 0);
		queue_date(17, 9, 16383, 0);
		queue_date(31, 14, 12345, 20000);

		run_phase(TRAFFIC_STEADY, 300);
		run_phase(TRAFFIC_SEND_IDLE, 250);
		run_phase(TRAFFIC_RECV_STALL, 250);
		run_phase(TRAFFIC_BOTH, 250);
		run_phase(TRAFFIC_HOLD, 300);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### gregorian_date_add_days_unit.f
sv/gdad_pkg.sv
sv/gdad_ctrl.sv
sv/gdad_dpath.sv
sv/gregorian_date_add_days_unit.sv
tb/gregorian_date_add_days_unit_test.sv
